>>> rtl/dq_pkg.sv
// types, constants and helpers shared by the double-ended queue modules
`default_nettype none

package dq_pkg;

   localparam int DEPTH      = 8;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = PTR_W + 1;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_READ_ALL   = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]                   cmd;
      logic signed [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [DATA_WIDTH-1:0] data;
      logic                         last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_WALK
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       walk_start;
      logic       walk_step;
      logic       rsp_load;
      logic       rsp_from_ram;
      logic [1:0] rsp_status;
      logic       rsp_last;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic walk_last;
   } sts_type;

   // reduce a slot number below 2*DEPTH into the buffer range
   function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] red;
      red = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
      return red[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/dq_ram.sv
// generic single-port ram with registered read
`default_nettype none

module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/dq_ctrl.sv
// command decoder and sequencing state machine of the queue
`default_nettype none

module dq_ctrl
   import dq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [2:0] cmd,
   input  wire sts_type    sts,
   output ctl_type         ctl,
   output logic            busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ctl            = '0;
      ctl.rsp_status = STATUS_OK;
      busy           = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     ctl.rsp_load = 1'b1;
                     ctl.rsp_last = 1'b1;
                     if (sts.full) begin
                        ctl.rsp_status = STATUS_FULL;
                     end else begin
                        ctl.push_front = (cmd == CMD_PUSH_FRONT);
                        ctl.push_back  = (cmd == CMD_PUSH_BACK);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (sts.empty) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_last   = 1'b1;
                        ctl.rsp_status = STATUS_EMPTY;
                     end else begin
                        ctl.pop_front = (cmd == CMD_POP_FRONT);
                        ctl.pop_back  = (cmd == CMD_POP_BACK);
                        state_in      = ST_POP;
                     end
                  end
                  CMD_READ_ALL: begin
                     if (sts.empty) begin
                        ctl.rsp_load   = 1'b1;
                        ctl.rsp_last   = 1'b1;
                        ctl.rsp_status = STATUS_EMPTY;
                     end else begin
                        ctl.walk_start = 1'b1;
                        state_in       = ST_WALK;
                     end
                  end
                  default: begin
                     // unknown commands are dropped without a result
                  end
               endcase
            end
         end
         ST_POP: begin
            ctl.rsp_load     = 1'b1;
            ctl.rsp_from_ram = 1'b1;
            ctl.rsp_last     = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_WALK: begin
            ctl.rsp_load     = 1'b1;
            ctl.rsp_from_ram = 1'b1;
            ctl.rsp_last     = sts.walk_last;
            if (sts.walk_last) begin
               state_in = ST_IDLE;
            end else begin
               ctl.walk_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/dq_dp.sv
// pointers, occupancy, entry storage and result register of the queue
`default_nettype none

module dq_dp
   import dq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctl_type               ctl,
   input  wire logic [DATA_WIDTH-1:0] push_value,
   output sts_type                    sts,
   output logic                       rsp_strobe,
   output rsp_type                    rsp_item
);

   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [PTR_W-1:0]      walk_ff, walk_in;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;

   logic [PTR_W-1:0]      head_dec, head_inc;
   logic [PTR_W-1:0]      occ_off, occ_m1_off, walk_nxt;
   logic [CNT_W-1:0]      occ_m1;
   logic [PTR_W-1:0]      back_slot, tail_slot, walk_slot;
   logic [PTR_W-1:0]      ram_addr;
   logic                  ram_we;
   logic [DATA_WIDTH-1:0] ram_rdata;

   assign head_dec   = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc   = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   // offsets below DEPTH only: occ_off is used when not full, occ_m1 when not empty
   assign occ_off    = occ_ff[PTR_W-1:0];
   assign occ_m1     = occ_ff - 1'b1;
   assign occ_m1_off = occ_m1[PTR_W-1:0];
   assign walk_nxt   = walk_ff + 1'b1;

   assign back_slot = wrap_slot({1'b0, head_ff} + {1'b0, occ_off});
   assign tail_slot = wrap_slot({1'b0, head_ff} + {1'b0, occ_m1_off});
   assign walk_slot = wrap_slot({1'b0, head_ff} + {1'b0, walk_nxt});

   assign sts.full      = (occ_ff == CNT_W'(DEPTH));
   assign sts.empty     = (occ_ff == '0);
   assign sts.walk_last = ((CNT_W'(walk_ff) + CNT_W'(1)) == occ_ff);

   always_comb begin
      priority if (ctl.push_front) begin
         ram_addr = head_dec;
      end else if (ctl.push_back) begin
         ram_addr = back_slot;
      end else if (ctl.pop_back) begin
         ram_addr = tail_slot;
      end else if (ctl.walk_step) begin
         ram_addr = walk_slot;
      end else begin
         // pop front and start of read-out both address the head
         ram_addr = head_ff;
      end
   end

   assign ram_we = ctl.push_front | ctl.push_back;

   dq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (push_value),
      .rdata (ram_rdata)
   );

   always_comb begin
      head_in = head_ff;
      occ_in  = occ_ff;
      walk_in = walk_ff;
      if (ctl.push_front) begin
         head_in = head_dec;
      end
      if (ctl.pop_front) begin
         head_in = head_inc;
      end
      if (ram_we) begin
         occ_in = occ_ff + 1'b1;
      end
      if (ctl.pop_front || ctl.pop_back) begin
         occ_in = occ_m1;
      end
      if (ctl.walk_start) begin
         walk_in = '0;
      end
      if (ctl.walk_step) begin
         walk_in = walk_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= ctl.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      if (ctl.rsp_load) begin
         rsp_ff.status <= ctl.rsp_status;
         rsp_ff.data   <= ctl.rsp_from_ram ? ram_rdata : '0;
         rsp_ff.last   <= ctl.rsp_last;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
// top level of the bounded double-ended queue of signed words
//
// Commands enter on req_item and are taken at a clock edge with start high
// and busy low: push front, push back, pop front, pop back, read all.
// Results leave on rsp_item, each valid for exactly one cycle while
// rsp_strobe is high; the receiver cannot stall this channel, so every
// result must be taken in the cycle it is shown.
// Pushes and refused commands give their single result in the cycle after the
// transfer and the next command may follow in that same cycle.
// A pop gives its word through the registered ram read and then the result
// register; busy stays high meanwhile, so the next command waits until it is shown.
// A read-out of N entries gives one result per cycle once the first entry is
// read from ram, with last set on the final one; busy stays high until that
// final result is shown.
// Codes 5 to 7 give no result and leave the queue as it was.
// Synchronous reset empties the queue, drops any command at work and
// clears the result strobe; entry storage is not cleared.
`default_nettype none

module double_ended_queue
   import dq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   ctl_type ctl;
   sts_type sts;

   dq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req_item.cmd),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   dq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .push_value (req_item.value),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

`ifndef SYNTHESIS
   // an unknown command gives no result and leaves the block free
   a_unknown_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.cmd > CMD_READ_ALL)) |=> (!rsp_strobe && !busy))
      else $error("unknown command produced a result or held busy");

   // refused commands always end their item
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != STATUS_OK)) |-> rsp_item.last)
      else $error("error result without last");

   // busy drops exactly as the final result of an item is shown
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_item.last))
      else $error("busy fell without final result");

   // a read-out result that is not the final one comes while the walk runs
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |-> busy)
      else $error("intermediate result while idle");

   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(sts.full && sts.empty))
      else $error("queue both full and empty");
`endif

endmodule

`default_nettype wire

>>> tb/double_ended_queue_test.sv
// self-checking testbench for the bounded double-ended queue
module double_ended_queue_test;
   import dq_pkg::*;

   // codes above read-all are not commands and give no result
   localparam logic [2:0] CMD_NONE_FIRST = 3'd5;
   localparam logic [2:0] CMD_NONE_LAST  = 3'd7;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int REPORT_LIMIT = 10;
   localparam int TAIL_CYCLES  = 20;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // shadow copy of the queue contents
   logic signed [DATA_WIDTH-1:0] stored_words [DEPTH];
   int front_slot;
   int fill_count;

   rsp_type expected_results [$];
   rsp_type want_result;
   int      mismatch_count;
   int      cycle_count;

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #4 clock = ~clock;

   // apply one accepted command to the shadow queue and queue up its results
   task automatic apply_deque_command(input req_type item);
      int      slot;
      rsp_type res;
      res.status = STATUS_OK;
      res.data   = '0;
      res.last   = 1'b1;
      case (item.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (fill_count == DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               if (item.cmd == CMD_PUSH_FRONT) begin
                  front_slot = (front_slot + DEPTH - 1) % DEPTH;
                  slot = front_slot;
               end else begin
                  slot = (front_slot + fill_count) % DEPTH;
               end
               stored_words[slot] = item.value;
               fill_count++;
            end
            expected_results.push_back(res);
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (fill_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               if (item.cmd == CMD_POP_FRONT) begin
                  slot = front_slot;
                  front_slot = (front_slot + 1) % DEPTH;
               end else begin
                  slot = (front_slot + fill_count - 1) % DEPTH;
               end
               res.data = stored_words[slot];
               fill_count--;
            end
            expected_results.push_back(res);
         end
         CMD_READ_ALL: begin
            if (fill_count == 0) begin
               res.status = STATUS_EMPTY;
               expected_results.push_back(res);
            end else begin
               for (int i = 0; i < fill_count; i++) begin
                  res.data = stored_words[(front_slot + i) % DEPTH];
                  res.last = (i == fill_count - 1);
                  expected_results.push_back(res);
               end
            end
         end
         default: ;
      endcase
   endtask

   // watch both channels at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result: status %0d data %0d last %0d",
                           rsp_item.status, rsp_item.data, rsp_item.last);
            end else begin
               want_result = expected_results.pop_front();
               if (rsp_item.status !== want_result.status ||
                   rsp_item.data !== want_result.data ||
                   rsp_item.last !== want_result.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("mismatch: expected status %0d data %0d last %0d,",
                              want_result.status, want_result.data, want_result.last,
                              " got status %0d data %0d last %0d",
                              rsp_item.status, rsp_item.data, rsp_item.last);
               end
            end
         end
         if (start && !busy)
            apply_deque_command(req_item);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // hold the command until its transfer; start stays high afterwards
   task automatic send_command(input logic [2:0] code,
                               input logic signed [DATA_WIDTH-1:0] word,
                               input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_item.cmd   <= code;
      req_item.value <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_queue();
      send_command(CMD_READ_ALL, $urandom, 0);
      send_command(CMD_POP_FRONT, $urandom, 0);
      send_command(CMD_POP_BACK, $urandom, 0);
   endtask

   task automatic test_unknown_codes();
      for (int c = CMD_NONE_FIRST; c <= CMD_NONE_LAST; c++)
         send_command(3'(c), $urandom, 0);
   endtask

   // extremes in and out, the second pop takes the only entry left
   task automatic test_single_entry();
      send_command(CMD_PUSH_BACK, {1'b0, {(DATA_WIDTH-1){1'b1}}}, 0);
      send_command(CMD_PUSH_FRONT, {1'b1, {(DATA_WIDTH-1){1'b0}}}, 0);
      send_command(CMD_POP_FRONT, '0, 0);
      send_command(CMD_POP_BACK, '1, 0);
   endtask

   task automatic test_fill_and_refuse();
      for (int i = 0; i < DEPTH / 2; i++)
         send_command(CMD_PUSH_FRONT, -(i + 1), 0);
      for (int i = 0; i < DEPTH / 2; i++)
         send_command(CMD_PUSH_BACK, 'h1000 + i, 0);
      send_command(CMD_PUSH_FRONT, $urandom, 0);
      send_command(CMD_PUSH_BACK, $urandom, 0);
      send_command(CMD_READ_ALL, $urandom, 0);
      send_command(CMD_POP_BACK, $urandom, 0);
      send_command(CMD_POP_FRONT, $urandom, 0);
      send_command(CMD_READ_ALL, $urandom, 0);
   endtask

   // bursts lean toward filling, draining or neither so full and empty both get hit
   task automatic test_random(input int count, input int gap_pct);
      int sent;
      int loops;
      int push_pct;
      int roll;
      logic [2:0] code;
      logic signed [DATA_WIDTH-1:0] word;
      sent = 0;
      loops = 0;
      push_pct = 50;
      while (sent < count) begin
         if (loops % 16 == 0) begin
            case ($urandom_range(2))
               0:       push_pct = 75;
               1:       push_pct = 25;
               default: push_pct = 50;
            endcase
         end
         loops++;
         roll = $urandom_range(99);
         if (roll < 4)
            code = 3'(CMD_NONE_FIRST + $urandom_range(CMD_NONE_LAST - CMD_NONE_FIRST));
         else if (roll < 16)
            code = CMD_READ_ALL;
         else if ($urandom_range(99) < push_pct)
            code = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         else
            code = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
         case ($urandom_range(7))
            0:       word = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1:       word = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2:       word = '1;
            3:       word = '0;
            default: word = $urandom;
         endcase
         send_command(code, word, gap_pct);
         if (code <= CMD_READ_ALL)
            sent++;
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      front_slot     = 0;
      fill_count     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_unknown_codes();
      test_single_entry();
      test_fill_and_refuse();
      test_random(75, 0);
      test_random(75, 65);
      // let every pending result come out before going on
      wait_until_drained();
      test_random(75, 37);
      test_random(75, 0);

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/dq_dp.sv
rtl/double_ended_queue.sv
tb/double_ended_queue_test.sv
